>>> sv/grc_pkg.sv
`timescale 1ns / 1ps
package grc_pkg;
    localparam int unsigned SatLow     = 40;
    localparam int unsigned SatHigh    = 8151;
    localparam int unsigned BoostSlope = 4;
    localparam int unsigned BoostLimit = 120;
    localparam int unsigned DiagMul    = 181;

    localparam logic [2:0] CfgOffsetX = 3'd0;
    localparam logic [2:0] CfgOffsetY = 3'd1;
    localparam logic [2:0] CfgOffsetZ = 3'd2;
    localparam logic [2:0] CfgQuad    = 3'd3;
    localparam logic [2:0] CfgMode    = 3'd4;
    localparam logic [2:0] CfgDiv     = 3'd5;
    localparam logic [2:0] CfgWin     = 3'd6;

    typedef struct packed {
        logic [12:0] raw_x;
        logic [12:0] raw_y;
        logic [12:0] raw_z;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic signed [15:0] deriv_x;
        logic signed [15:0] deriv_y;
        logic               limit_hit;
    } t_out_word;

    typedef struct packed {
        logic               start;
        logic signed [15:0] sample;
        logic [7:0]         divisor;
    } t_lane_cmd;

    typedef struct packed {
        logic               done;
        logic signed [15:0] filt;
        logic signed [15:0] diff;
    } t_lane_rsp;

    // sign table for the 45 degree rotation
    function automatic logic signed [1:0] rot_sign(input logic [2:0] q);
        logic signed [1:0] s;
        case (q)
            3'd0, 3'd1, 3'd7: s = 2'sd1;
            3'd2, 3'd6:       s = 2'sd0;
            default:          s = -2'sd1;
        endcase
        return s;
    endfunction
endpackage

>>> sv/grc_stream_if.sv
`timescale 1ns / 1ps
interface grc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/grc_front.sv
`timescale 1ns / 1ps
module grc_front (
    input  logic [12:0]        i_raw_x,
    input  logic [12:0]        i_raw_y,
    input  logic [12:0]        i_raw_z,
    input  logic [12:0]        i_off_x,
    input  logic [12:0]        i_off_y,
    input  logic [12:0]        i_off_z,
    input  logic [2:0]         i_quad,
    input  logic [2:0]         i_mode,
    output logic signed [17:0] o_t0,
    output logic signed [17:0] o_t1,
    output logic signed [15:0] o_z,
    output logic               o_hit
);
    import grc_pkg::*;

    logic signed [15:0] v0, v1;
    logic               h0, h1;
    logic signed [1:0]  xx, xy, yx, yy;

    function automatic logic [15:0] boost(input logic [12:0] t, input logic en,
                                          output logic hit);
        logic [15:0] r;
        r   = {3'b0, t};
        hit = 1'b0;
        if (en && t < 13'(SatLow)) begin
            hit = 1'b1;
            r   = 16'({3'b0, t} * 16'(BoostSlope)) - 16'(BoostLimit);
        end else if (en && t > 13'(SatHigh)) begin
            hit = 1'b1;
            r   = 16'(({3'b0, t} - 16'(SatHigh)) * 16'(BoostSlope)) + 16'(SatHigh);
        end
        return r;
    endfunction

    always_comb begin
        v0 = boost(i_raw_x, i_mode[0], h0) - {3'b0, i_off_x};
        v1 = boost(i_raw_y, i_mode[0], h1) - {3'b0, i_off_y};
        o_hit = h0 | h1;
        xx = i_mode[1] ? rot_sign(i_quad + 3'd4) : rot_sign(i_quad);
        xy = rot_sign(i_quad + 3'd2);
        yx = i_mode[1] ? rot_sign(i_quad + 3'd2) : rot_sign(i_quad + 3'd6);
        yy = rot_sign(i_quad);
        o_t0 = 18'(xx * v0) + 18'(xy * v1);
        o_t1 = 18'(yx * v0) + 18'(yy * v1);
        o_z = i_mode[2] ? 16'({3'b0, i_off_z} - {3'b0, i_raw_z})
                        : 16'({3'b0, i_raw_z} - {3'b0, i_off_z});
    end
endmodule

>>> sv/grc_lane.sv
`timescale 1ns / 1ps
module grc_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  grc_pkg::t_lane_cmd  i_cmd,
    output grc_pkg::t_lane_rsp  o_rsp
);
    import grc_pkg::*;

    // serial restoring divider over |num|, 24 steps
    logic signed [15:0] r_old;
    logic [23:0]        r_quo, n_quo;
    logic [8:0]         r_rem, n_rem;
    logic [7:0]         r_div;
    logic               r_neg, r_busy, r_done;
    logic [4:0]         r_cnt;
    logic signed [31:0] num;
    logic [31:0]        mag;
    logic [7:0]         k;
    logic [8:0]         trial;
    logic signed [15:0] quo16, nf;

    always_comb begin
        k     = (i_cmd.divisor == 8'd0) ? 8'd1 : i_cmd.divisor;
        num   = 32'(r_old) * 32'($signed({1'b0, k} - 9'sd1)) + 32'(i_cmd.sample);
        mag   = num[31] ? 32'(-num) : num;
        trial = {r_rem[7:0], r_quo[23]};
        n_rem = trial;
        n_quo = {r_quo[22:0], 1'b0};
        if (trial >= {1'b0, r_div}) begin
            n_rem  = trial - {1'b0, r_div};
            n_quo[0] = 1'b1;
        end
        quo16 = r_neg ? 16'(-r_quo[15:0]) : r_quo[15:0];
        nf    = quo16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_old  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd24;
                r_quo  <= mag[23:0];
                r_rem  <= '0;
                r_div  <= k;
                r_neg  <= num[31];
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (r_done) r_old <= nf;
        end
    end

    // |num| < 2^23 since |old*254 + in| is bounded
    assign o_rsp.done = r_done;
    assign o_rsp.filt = nf;
    assign o_rsp.diff = nf - r_old;
endmodule

>>> sv/grc_merge.sv
`timescale 1ns / 1ps
module grc_merge #(
    parameter int DerivDepth = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [3:0]         i_win,
    input  grc_pkg::t_lane_rsp i_rsp_x,
    input  grc_pkg::t_lane_rsp i_rsp_y,
    output logic signed [15:0] o_dx,
    output logic signed [15:0] o_dy
);
    import grc_pkg::*;
    localparam int PW = (DerivDepth > 1) ? $clog2(DerivDepth) : 1;

    logic signed [15:0] r_hx [DerivDepth];
    logic signed [15:0] r_hy [DerivDepth];
    logic signed [15:0] r_sx, r_sy;
    logic [PW-1:0]      r_pos;
    logic [5:0]         len;
    logic [5:0]         nxt;

    always_comb begin
        len = {2'b0, i_win};
        if (len == 6'd0) len = 6'd1;
        if (len > 6'(DerivDepth)) len = 6'(DerivDepth);
        nxt = 6'(r_pos) + 6'd1;
        if (nxt >= len) nxt = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_pos <= '0;
            for (int i = 0; i < DerivDepth; i++) begin
                r_hx[i] <= '0;
                r_hy[i] <= '0;
            end
        end else if (i_go) begin
            r_sx        <= r_sx - r_hx[r_pos] + i_rsp_x.diff;
            r_sy        <= r_sy - r_hy[r_pos] + i_rsp_y.diff;
            r_hx[r_pos] <= i_rsp_x.diff;
            r_hy[r_pos] <= i_rsp_y.diff;
            r_pos       <= nxt[PW-1:0];
        end
    end

    assign o_dx = r_sx;
    assign o_dy = r_sy;
endmodule

>>> sv/gyro_rate_conditioner_core.sv
`timescale 1ns / 1ps
// Gyro rate conditioner.
// in_ch carries one word of raw X/Y/Z sums; out_ch carries one word of
// filtered rates, Z rate, derivative terms and the saturation flag.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data, write only, idle time only.
// Flow: a word is taken when the block is empty; offset, boost and rotation
// are computed combinationally and registered on accept, diagonal scaling is
// registered in S_SCALE, then both lanes run a 24-step serial divider for
// the IIR filter in parallel and a merge stage updates the derivative windows.
// One word in flight: no new word is accepted until the result is taken.
// Reset clears filters, derivative sums, history and config registers to defaults.
// If the receiver stalls the result is held in the output register and no
// new word is accepted until it is taken.
module gyro_rate_conditioner_core #(
    parameter int DERIV_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    grc_stream_if.sink   in_ch,
    grc_stream_if.source out_ch
);
    import grc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_SCALE = 5'b00010, S_START = 5'b00100,
        S_DIV = 5'b01000, S_OUT = 5'b10000
    } t_state;

    t_state r_state;
    logic [12:0] r_off_x, r_off_y, r_off_z;
    logic [2:0]  r_quad, r_mode;
    logic [7:0]  r_div;
    logic [3:0]  r_win;
    logic signed [17:0] r_t0, r_t1, f_t0, f_t1;
    logic signed [15:0] r_z, f_z, r_s0, r_s1;
    logic        r_hit, f_hit, r_merge;
    logic signed [25:0] p0, p1;
    t_lane_cmd   cmd_x, cmd_y;
    t_lane_rsp   rsp_x, rsp_y;
    logic signed [15:0] dx, dy;
    t_in_word    iw;
    t_out_word   r_out;

    assign iw = in_ch.data;

    grc_front u_front (
        .i_raw_x(iw.raw_x), .i_raw_y(iw.raw_y), .i_raw_z(iw.raw_z),
        .i_off_x(r_off_x), .i_off_y(r_off_y), .i_off_z(r_off_z),
        .i_quad(r_quad), .i_mode(r_mode),
        .o_t0(f_t0), .o_t1(f_t1), .o_z(f_z), .o_hit(f_hit)
    );

    always_comb begin
        p0 = 26'(r_t0) * $signed(26'(DiagMul));
        p1 = 26'(r_t1) * $signed(26'(DiagMul));
        cmd_x.start   = (r_state == S_START);
        cmd_x.sample  = r_s0;
        cmd_x.divisor = r_div;
        cmd_y.start   = (r_state == S_START);
        cmd_y.sample  = r_s1;
        cmd_y.divisor = r_div;
    end

    grc_lane u_lane_x (.i_clk, .i_rst_n, .i_cmd(cmd_x), .o_rsp(rsp_x));
    grc_lane u_lane_y (.i_clk, .i_rst_n, .i_cmd(cmd_y), .o_rsp(rsp_y));

    grc_merge #(.DerivDepth(DERIV_DEPTH)) u_merge (
        .i_clk, .i_rst_n, .i_go(rsp_x.done), .i_win(r_win),
        .i_rsp_x(rsp_x), .i_rsp_y(rsp_y), .o_dx(dx), .o_dy(dy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= 13'd4096;
            r_off_y <= 13'd4096;
            r_off_z <= 13'd2048;
            r_quad  <= '0;
            r_mode  <= '0;
            r_div   <= 8'd1;
            r_win   <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgOffsetX: r_off_x <= i_cfg_data;
                CfgOffsetY: r_off_y <= i_cfg_data;
                CfgOffsetZ: r_off_z <= i_cfg_data;
                CfgQuad:    r_quad  <= i_cfg_data[2:0];
                CfgMode:    r_mode  <= i_cfg_data[2:0];
                CfgDiv:     r_div   <= i_cfg_data[7:0];
                CfgWin:     r_win   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_merge <= 1'b0;
        end else begin
            r_merge <= rsp_x.done;
            unique case (r_state)
                S_IDLE: if (in_ch.valid) r_state <= S_SCALE;
                S_SCALE: r_state <= S_START;
                S_START: r_state <= S_DIV;
                S_DIV: if (r_merge) r_state <= S_OUT;
                S_OUT: if (out_ch.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_ch.valid) begin
            r_t0  <= f_t0;
            r_t1  <= f_t1;
            r_z   <= f_z;
            r_hit <= f_hit;
        end
        if (r_state == S_SCALE) begin
            r_s0 <= r_quad[0] ? p0[23:8] : r_t0[15:0];
            r_s1 <= r_quad[0] ? p1[23:8] : r_t1[15:0];
        end
        if (rsp_x.done) begin
            r_out.rate_x <= rsp_x.filt;
            r_out.rate_y <= rsp_y.filt;
        end
        if (r_merge) begin
            r_out.rate_z    <= r_z;
            r_out.deriv_x   <= dx;
            r_out.deriv_y   <= dy;
            r_out.limit_hit <= r_hit;
        end
    end

    assign in_ch.ready  = (r_state == S_IDLE);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.data  = r_out;

    a_lanes_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_x.done == rsp_y.done) else $error("lanes out of step");
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("accept while holding result");
    a_merge_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_merge && r_state == S_DIV |=> out_ch.valid) else $error("result lost");
endmodule

>>> dv/tb_gyro_rate_conditioner_core.sv
`timescale 1ns / 1ps
module tb_gyro_rate_conditioner_core;
    import grc_pkg::*;

    localparam int Depth = 8;
    localparam int Latency = 40;
    localparam int MaxCycles = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = CfgOffsetX;
    logic [12:0] i_cfg_data = '0;

    grc_stream_if #(.T(t_in_word))  in_ch ();
    grc_stream_if #(.T(t_out_word)) out_ch ();

    gyro_rate_conditioner_core #(.DERIV_DEPTH(Depth)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [12:0] off_x, off_y, off_z;
    logic [2:0]  quad, mode;
    logic [7:0]  fdiv;
    logic [3:0]  win;
    logic signed [15:0] filt_q [2];
    logic signed [15:0] dsum_q [2];
    logic signed [15:0] hist_q [2][Depth];
    int unsigned hpos;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int fail_cnt = 0;
    int cycle_cnt = 0;
    logic in_taken = 1'b0;

    function automatic int sgn(input int q);
        case (q & 7)
            0, 1, 7: return 1;
            2, 6:    return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int diag(input int v);
        int p;
        p = v * 181;
        return p >>> 8;
    endfunction

    function automatic t_out_word condition_word(input t_in_word w);
        t_out_word o;
        int raw [2];
        int offs [2];
        int v [2];
        int r [2];
        int t, xx, xy, yx, yy, k, len, pos, t0, t1, nf, oldf;
        logic signed [15:0] d16, nf16;
        logic hit;
        raw[0] = w.raw_x;
        raw[1] = w.raw_y;
        offs[0] = off_x;
        offs[1] = off_y;
        hit = 1'b0;
        for (int a = 0; a < 2; a++) begin
            t = raw[a];
            if (mode[0]) begin
                if (t < SatLow) begin
                    hit = 1'b1;
                    t = 16'(t * BoostSlope - BoostLimit);
                    t = $signed(16'(t));
                end else if (t > SatHigh) begin
                    hit = 1'b1;
                    t = $signed(16'((t - SatHigh) * BoostSlope + SatHigh));
                end
            end
            v[a] = $signed(16'(t - offs[a]));
        end
        xx = mode[1] ? sgn(quad + 4) : sgn(quad);
        xy = sgn(quad + 2);
        yx = mode[1] ? sgn(quad + 2) : sgn(quad + 6);
        yy = sgn(quad);
        t0 = xx * v[0] + xy * v[1];
        t1 = yx * v[0] + yy * v[1];
        if (quad[0]) begin
            t0 = diag(t0);
            t1 = diag(t1);
        end
        r[0] = $signed(16'(t0));
        r[1] = $signed(16'(t1));
        k = (fdiv == 0) ? 1 : fdiv;
        pos = hpos % Depth;
        for (int a = 0; a < 2; a++) begin
            oldf = filt_q[a];
            nf = (oldf * (k - 1) + r[a]) / k;
            nf16 = 16'(nf);
            d16 = 16'(nf16 - oldf);
            dsum_q[a] = dsum_q[a] - hist_q[a][pos] + d16;
            hist_q[a][pos] = d16;
            filt_q[a] = nf16;
        end
        len = (win == 0) ? 1 : ((win > Depth) ? Depth : win);
        pos = pos + 1;
        if (pos >= len) pos = 0;
        hpos = pos;
        o.rate_x = filt_q[0];
        o.rate_y = filt_q[1];
        o.rate_z = mode[2] ? 16'(off_z - w.raw_z) : 16'(w.raw_z - off_z);
        o.deriv_x = dsum_q[0];
        o.deriv_y = dsum_q[1];
        o.limit_hit = hit;
        return o;
    endfunction

    // driver: bursts and gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            in_ch.valid <= 1'b1;
            in_ch.data <= pending_words.pop_front();
            if (burst_left == 0) begin
                burst_left <= $urandom_range(8, 1);
                gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if (stall_phase % 600 < 200) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(3, 0) != 0);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            expected_words.push_back(condition_word(in_ch.data));
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word exp none act %p", $time, out_ch.data);
                fail_cnt <= fail_cnt + 1;
            end else begin
                t_out_word e;
                e = expected_words.pop_front();
                if (e !== out_ch.data) begin
                    $display("%0t: mismatch exp %p act %p", $time, e, out_ch.data);
                    fail_cnt <= fail_cnt + 1;
                end
            end
        end
        if (cycle_cnt > MaxCycles) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgOffsetX: off_x = val;
            CfgOffsetY: off_y = val;
            CfgOffsetZ: off_z = val;
            CfgQuad:    quad = val[2:0];
            CfgMode:    mode = val[2:0];
            CfgDiv:     fdiv = val[7:0];
            default:    win = val[3:0];
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_ch.valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (Latency) @(posedge i_clk);
    endtask

    function automatic logic [12:0] rand_raw();
        case ($urandom_range(5, 0))
            0: return 13'($urandom_range(SatLow + 2, 0));
            1: return 13'($urandom_range(8191, SatHigh - 2));
            default: return 13'($urandom_range(8191, 0));
        endcase
    endfunction

    task automatic push_word(input logic [12:0] x, y, z);
        t_in_word w;
        w.raw_x = x;
        w.raw_y = y;
        w.raw_z = z;
        pending_words.push_back(w);
    endtask

    initial begin
        off_x = 4096; off_y = 4096; off_z = 2048;
        quad = 0; mode = 0; fdiv = 1; win = 8;
        filt_q = '{default: '0};
        dsum_q = '{default: '0};
        hist_q = '{default: '{default: '0}};
        hpos = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, thresholds, each quadrant and mode
        write_reg(CfgMode, 13'd1);
        push_word(0, 8191, 0);
        push_word(8191, 0, 8191);
        push_word(39, 40, 4096);
        push_word(8151, 8152, 1);
        for (int q = 0; q < 8; q++) begin
            push_word(13'($urandom_range(8191, 0)), 13'($urandom_range(8191, 0)), 100);
        end
        drain();
        for (int q = 0; q < 8; q++) begin
            write_reg(CfgQuad, 13'(q));
            write_reg(CfgMode, 13'(q));
            push_word(8191, 0, 8191);
            push_word(0, 8191, 0);
            drain();
        end
        write_reg(CfgDiv, 13'd0);
        write_reg(CfgWin, 13'd0);
        push_word(5000, 3000, 10);
        push_word(1000, 7000, 20);
        drain();

        // random phases over settings
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(CfgOffsetX, (ph == 0) ? 13'd0 : (ph == 1) ? 13'd8191
                : 13'($urandom_range(8191, 0)));
            write_reg(CfgOffsetY, (ph == 0) ? 13'd8191 : (ph == 1) ? 13'd0
                : 13'($urandom_range(8191, 0)));
            write_reg(CfgOffsetZ, (ph == 0) ? 13'd0 : 13'($urandom_range(8191, 0)));
            write_reg(CfgQuad, 13'($urandom_range(7, 0)));
            write_reg(CfgMode, 13'($urandom_range(7, 0)));
            write_reg(CfgDiv, (ph == 2) ? 13'd255 : (ph == 3) ? 13'd1
                : 13'($urandom_range(255, 0)));
            write_reg(CfgWin, (ph == 4) ? 13'd15 : 13'($urandom_range(15, 0)));
            repeat (80) push_word(rand_raw(), rand_raw(), 13'($urandom_range(8191, 0)));
            drain();
        end

        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
